@@ src/mpbsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Signature matcher package
// Shared constants, types and the score function of the byte signature
// matcher.
// ----------------------------------------------------------------------------
package mpbsm_pkg;

    localparam int NUM_SIGNATURES_DEFAULT    = 8;
    localparam int MAX_SIGNATURE_LEN_DEFAULT = 5;

    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_W      = 43;
    localparam int LEN_LSB     = 40;
    localparam int LEN_W       = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 4;
    localparam int SCORE_W     = 7;
    localparam int MASK_W      = 8;

    localparam logic [7:0] SCORE_STEP = 8'd15;
    localparam logic [7:0] SCORE_MAX  = 8'd100;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [7:0]         byte_t;
    typedef logic [LEN_W-1:0]   sig_len_t;

    localparam slot_t SLOT_RESET [SLOT_COUNT] = '{
        43'd4400471904400, 43'd4401482484940, 43'd2199023256847, 43'd2199023288525,
        43'd4398046511336, 43'd2199023265279, 43'd3298547517256, 43'd5976118551912
    };

    // Fifteen points per signature found, capped at one hundred.
    function automatic logic [SCORE_W-1:0] score_of(input logic [COUNT_W-1:0] count);
        logic [7:0] product;
        product = 8'(count) * SCORE_STEP;
        if (product > SCORE_MAX)
        begin
            product = SCORE_MAX;
        end
        return product[SCORE_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ src/multi_pattern_byte_signature_match_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-pattern byte signature matcher
// Scans a buffer byte by byte against eight configurable signatures and
// reports the found mask, match count and score on the buffer's last byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle. All signature slots compare the
// newest byte and the held history in parallel in the cycle it is accepted,
// and the result is presented from an output register in the cycle after
// the last byte of a buffer is accepted. Non-last bytes are taken even while
// a result waits; only a last byte is held off until the waiting result has
// been taken, since the output register is the one place for it. The user
// must write signature slots through the configuration port between buffers;
// the block does not enforce it. Slot writes take effect at the next byte.
module multi_pattern_byte_signature_match_top
#(
    parameter int NUM_SIGNATURES    = mpbsm_pkg::NUM_SIGNATURES_DEFAULT,
    parameter int MAX_SIGNATURE_LEN = mpbsm_pkg::MAX_SIGNATURE_LEN_DEFAULT
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_wr_en,
    input  wire logic [mpbsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mpbsm_pkg::SLOT_W-1:0]      cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             last_byte,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [mpbsm_pkg::MASK_W-1:0]          found_mask,
    output logic [mpbsm_pkg::COUNT_W-1:0]         match_count,
    output logic [mpbsm_pkg::SCORE_W-1:0]         score_percent
);

    import mpbsm_pkg::*;

    localparam int HIST_BYTES = MAX_SIGNATURE_LEN - 1;
    localparam int HIST_LEN   = (HIST_BYTES > 0) ? HIST_BYTES : 1;
    localparam int SEEN_W     = (MAX_SIGNATURE_LEN > 1) ? $clog2(MAX_SIGNATURE_LEN) : 1;

    slot_t               slot_reg [NUM_SIGNATURES];
    byte_t               history_reg [HIST_LEN];
    byte_t               history_next [HIST_LEN];
    logic [SEEN_W-1:0]   bytes_seen_reg;
    logic [SEEN_W-1:0]   bytes_seen_next;
    logic [NUM_SIGNATURES-1:0] found_reg;
    logic [NUM_SIGNATURES-1:0] found_next;

    logic                out_valid_reg;
    logic [MASK_W-1:0]   found_mask_reg;
    logic [COUNT_W-1:0]  match_count_reg;
    logic [SCORE_W-1:0]  score_reg;

    byte_t               window [MAX_SIGNATURE_LEN];
    logic [NUM_SIGNATURES-1:0] hit;
    logic [MASK_W-1:0]   mask_next;
    logic [COUNT_W-1:0]  count_next;
    logic                in_accept;

    assign in_stall  = out_valid_reg && out_stall && last_byte;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        for (int k = 0; k < MAX_SIGNATURE_LEN - 1; k++)
        begin
            window[k] = history_reg[k];
        end
        window[MAX_SIGNATURE_LEN-1] = data_byte;
    end

    // Each slot compares its tail against every possible length and then
    // keeps the comparison that its length field selects.
    always_comb
    begin
        sig_len_t len;
        logic     tail_eq;
        for (int s = 0; s < NUM_SIGNATURES; s++)
        begin
            len    = slot_reg[s][LEN_LSB +: LEN_W];
            hit[s] = 1'b0;
            for (int l = 1; l <= MAX_SIGNATURE_LEN; l++)
            begin
                tail_eq = (int'(bytes_seen_reg) + 1 >= l);
                for (int k = 0; k < l; k++)
                begin
                    if (slot_reg[s][8*k +: 8] != window[MAX_SIGNATURE_LEN - l + k])
                    begin
                        tail_eq = 1'b0;
                    end
                end
                if (len == LEN_W'(l) && tail_eq)
                begin
                    hit[s] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [NUM_SIGNATURES-1:0] flags;
        flags      = found_reg | hit;
        mask_next  = MASK_W'(flags);
        count_next = '0;
        for (int s = 0; s < NUM_SIGNATURES; s++)
        begin
            count_next = count_next + COUNT_W'(flags[s]);
        end

        if (last_byte)
        begin
            found_next      = '0;
            bytes_seen_next = '0;
            for (int k = 0; k < HIST_LEN; k++)
            begin
                history_next[k] = '0;
            end
        end
        else
        begin
            found_next = flags;
            if (int'(bytes_seen_reg) < HIST_BYTES)
            begin
                bytes_seen_next = bytes_seen_reg + SEEN_W'(1);
            end
            else
            begin
                bytes_seen_next = bytes_seen_reg;
            end
            history_next[HIST_LEN-1] = '0;
            for (int k = 0; k < HIST_BYTES; k++)
            begin
                history_next[k] = window[k+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SIGNATURES; s++)
            begin
                slot_reg[s] <= SLOT_RESET[s];
            end
        end
        else if (cfg_wr_en)
        begin
            for (int s = 0; s < NUM_SIGNATURES; s++)
            begin
                if (cfg_index == CFG_INDEX_W'(s))
                begin
                    slot_reg[s] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            found_reg      <= '0;
            for (int k = 0; k < HIST_LEN; k++)
            begin
                history_reg[k] <= '0;
            end
        end
        else if (in_accept)
        begin
            bytes_seen_reg <= bytes_seen_next;
            found_reg      <= found_next;
            history_reg    <= history_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && last_byte)
        begin
            found_mask_reg  <= mask_next;
            match_count_reg <= count_next;
            score_reg       <= score_of(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign found_mask    = found_mask_reg;
    assign match_count   = match_count_reg;
    assign score_percent = score_reg;

    // A last byte that is accepted always leaves a result waiting.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> out_valid)
        else $error("accepted last byte produced no result");

    // The buffer state starts over after a last byte.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> (bytes_seen_reg == '0 && found_reg == '0))
        else $error("buffer state not cleared after last byte");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(match_count) == $countones(found_mask)))
        else $error("match count disagrees with found mask");

    a_score_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (score_percent == 7'd100
                       || 8'(score_percent) == 8'(match_count) * SCORE_STEP))
        else $error("score does not follow match count");

endmodule
`default_nettype wire
